@@ rtl/klcs_pkg.sv @@
// Shared types, codes and constants for the keyboard LED command sender.
package klcs_pkg;

    // Field widths
    localparam int unsigned ActionW  = 2;
    localparam int unsigned MaskW    = 3;
    localparam int unsigned ByteW    = 8;
    localparam int unsigned StatusW  = 2;
    localparam int unsigned RetryW   = 3;
    localparam int unsigned TimeoutW = 16;
    localparam int unsigned PaddrW   = 3;
    localparam int unsigned PdataW   = 32;

    // Action codes of an input word
    localparam logic [ActionW-1:0] ACT_START = 2'd0;
    localparam logic [ActionW-1:0] ACT_REPLY = 2'd1;
    localparam logic [ActionW-1:0] ACT_TICK  = 2'd2;

    // Keyboard protocol bytes
    localparam logic [ByteW-1:0] CMD_SET_LEDS = 8'hED;
    localparam logic [ByteW-1:0] REPLY_ACK    = 8'hFA;
    localparam logic [ByteW-1:0] REPLY_RESEND = 8'hFE;

    // Completion status codes
    localparam logic [StatusW-1:0] ST_OK      = 2'd0;
    localparam logic [StatusW-1:0] ST_TIMEOUT = 2'd1;
    localparam logic [StatusW-1:0] ST_RETRIES = 2'd2;

    // Register indexes (word address bit)
    localparam logic REG_RETRY_LIMIT   = 1'b0;
    localparam logic REG_REPLY_TIMEOUT = 1'b1;

    // Register reset values
    localparam logic [RetryW-1:0]   RETRY_LIMIT_RST   = 3'd3;
    localparam logic [TimeoutW-1:0] REPLY_TIMEOUT_RST = 16'd60000;

    // Exchange phase, one-hot
    typedef enum logic [2:0] {
        PH_IDLE      = 3'b001,
        PH_WAIT_CMD  = 3'b010,
        PH_WAIT_MASK = 3'b100
    } t_phase;

    // Configuration seen by the controller
    typedef struct packed {
        logic [RetryW-1:0]   retry_limit;
        logic [TimeoutW-1:0] reply_timeout;
    } t_cfg;

    // One result word
    typedef struct packed {
        logic               write_valid;
        logic [ByteW-1:0]   write_byte;
        logic               done_res;
        logic [StatusW-1:0] status;
    } t_result;

endpackage

@@ rtl/klcs_if.sv @@
// Stream interfaces for input words and result words.
interface klcs_in_if;
    logic                          valid;
    logic                          ready;
    logic [klcs_pkg::ActionW-1:0]  action;
    logic [klcs_pkg::MaskW-1:0]    led_mask;
    logic [klcs_pkg::ByteW-1:0]    reply_byte;

    modport source (output valid, action, led_mask, reply_byte, input ready);
    modport sink   (input valid, action, led_mask, reply_byte, output ready);
endinterface

interface klcs_out_if;
    logic                          valid;
    logic                          ready;
    logic                          write_valid;
    logic [klcs_pkg::ByteW-1:0]    write_byte;
    logic                          done_res;
    logic [klcs_pkg::StatusW-1:0]  status;

    modport source (output valid, write_valid, write_byte, done_res, status, input ready);
    modport sink   (input valid, write_valid, write_byte, done_res, status, output ready);
endinterface

@@ rtl/klcs_apb_regs.sv @@
// APB configuration registers: retry limit and reply timeout.
module klcs_apb_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [klcs_pkg::PaddrW-1:0]   paddr,
    input  logic [klcs_pkg::PdataW-1:0]   pwdata,
    output logic [klcs_pkg::PdataW-1:0]   prdata,
    output logic                          pready,
    output klcs_pkg::t_cfg                o_cfg
);
    import klcs_pkg::*;

    logic [RetryW-1:0]   r_retry_limit;
    logic [TimeoutW-1:0] r_reply_timeout;
    logic                w_wr;
    logic                w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign w_idx  = paddr[2];

    // Write registers on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_limit   <= RETRY_LIMIT_RST;
            r_reply_timeout <= REPLY_TIMEOUT_RST;
        end else if (w_wr) begin
            if (w_idx == REG_RETRY_LIMIT) begin
                r_retry_limit <= pwdata[RetryW-1:0];
            end else begin
                r_reply_timeout <= pwdata[TimeoutW-1:0];
            end
        end
    end

    // Return the addressed register
    always_comb begin
        if (w_idx == REG_RETRY_LIMIT) begin
            prdata = {{(PdataW-RetryW){1'b0}}, r_retry_limit};
        end else begin
            prdata = {{(PdataW-TimeoutW){1'b0}}, r_reply_timeout};
        end
    end

    assign o_cfg.retry_limit   = r_retry_limit;
    assign o_cfg.reply_timeout = r_reply_timeout;

endmodule

@@ rtl/klcs_ctrl.sv @@
// Exchange controller: phase, attempt and timeout state, result word per input word.
module klcs_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [klcs_pkg::ActionW-1:0]  i_action,
    input  logic [klcs_pkg::MaskW-1:0]    i_led_mask,
    input  logic [klcs_pkg::ByteW-1:0]    i_reply_byte,
    input  klcs_pkg::t_cfg                i_cfg,
    output klcs_pkg::t_result             o_result,
    output logic                          o_busy
);
    import klcs_pkg::*;

    t_phase              r_phase,   n_phase;
    logic [RetryW-1:0]   r_attempt, n_attempt;
    logic [TimeoutW-1:0] r_wait,    n_wait;
    logic [MaskW-1:0]    r_mask,    n_mask;
    logic [ByteW-1:0]    w_cur_byte;
    logic                w_busy;

    assign w_busy     = (r_phase != PH_IDLE);
    assign o_busy     = w_busy;
    assign w_cur_byte = (r_phase == PH_WAIT_CMD) ? CMD_SET_LEDS
                                                 : {{(ByteW-MaskW){1'b0}}, r_mask};

    // Next state and result for the accepted word
    always_comb begin
        n_phase   = r_phase;
        n_attempt = r_attempt;
        n_wait    = r_wait;
        n_mask    = r_mask;
        o_result  = '0;
        if (i_accept) begin
            unique case (i_action)
                ACT_START: begin
                    if (!w_busy) begin
                        n_mask               = i_led_mask;
                        n_phase              = PH_WAIT_CMD;
                        n_attempt            = RetryW'(1);
                        n_wait               = i_cfg.reply_timeout;
                        o_result.write_valid = 1'b1;
                        o_result.write_byte  = CMD_SET_LEDS;
                    end
                end
                ACT_REPLY: begin
                    if (w_busy) begin
                        if (i_reply_byte == REPLY_ACK) begin
                            if (r_phase == PH_WAIT_CMD) begin
                                n_phase              = PH_WAIT_MASK;
                                n_attempt            = RetryW'(1);
                                n_wait               = i_cfg.reply_timeout;
                                o_result.write_valid = 1'b1;
                                o_result.write_byte  = {{(ByteW-MaskW){1'b0}}, r_mask};
                            end else begin
                                n_phase           = PH_IDLE;
                                n_attempt         = '0;
                                n_wait            = '0;
                                o_result.done_res = 1'b1;
                                o_result.status   = ST_OK;
                            end
                        end else if (i_reply_byte == REPLY_RESEND) begin
                            if (r_attempt < i_cfg.retry_limit) begin
                                n_attempt            = r_attempt + RetryW'(1);
                                n_wait               = i_cfg.reply_timeout;
                                o_result.write_valid = 1'b1;
                                o_result.write_byte  = w_cur_byte;
                            end else begin
                                n_phase           = PH_IDLE;
                                n_attempt         = '0;
                                n_wait            = '0;
                                o_result.done_res = 1'b1;
                                o_result.status   = ST_RETRIES;
                            end
                        end
                    end
                end
                ACT_TICK: begin
                    if (w_busy) begin
                        if (r_wait <= TimeoutW'(1)) begin
                            n_phase           = PH_IDLE;
                            n_attempt         = '0;
                            n_wait            = '0;
                            o_result.done_res = 1'b1;
                            o_result.status   = ST_TIMEOUT;
                        end else begin
                            n_wait = r_wait - TimeoutW'(1);
                        end
                    end
                end
                default: begin
                    // unused action: no state change, empty result
                end
            endcase
        end
    end

    // Hold exchange state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_attempt <= '0;
            r_wait    <= '0;
            r_mask    <= '0;
        end else begin
            r_phase   <= n_phase;
            r_attempt <= n_attempt;
            r_wait    <= n_wait;
            r_mask    <= n_mask;
        end
    end

endmodule

@@ rtl/klcs_out_reg.sv @@
// Result register between the controller and the output channel.
module klcs_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  klcs_pkg::t_result  i_result,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output klcs_pkg::t_result  o_result,
    output logic               o_free
);
    import klcs_pkg::*;

    logic    r_valid;
    t_result r_result;

    // Free when empty or when the held word leaves this cycle
    assign o_free      = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_result    = r_result;

    // Track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Capture the result word
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

@@ rtl/keyboard_led_command_sender.sv @@
// Top level of the keyboard set-LEDs command sender.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+---------------------------------------------
//  i_cmd    | in  | valid/ready   | action, led_mask, reply_byte
//  o_res    | out | valid/ready   | write_valid, write_byte, done_res, status
//  apb      | in  | psel/penable  | paddr 0 retry_limit, paddr 4 reply_timeout
//
//  One word per cycle: each accepted word updates the exchange state and loads
//  one result word into the result register in the same cycle.
//  The input is ready whenever the result register is empty or being drained,
//  so a stalled output holds one word and stops input after that.
//  Reset (synchronous, active low) returns to idle and restores register defaults.
module keyboard_led_command_sender (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    klcs_in_if.sink                       i_cmd,
    klcs_out_if.source                    o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [klcs_pkg::PaddrW-1:0]   paddr,
    input  logic [klcs_pkg::PdataW-1:0]   pwdata,
    output logic [klcs_pkg::PdataW-1:0]   prdata,
    output logic                          pready
);
    import klcs_pkg::*;

    t_cfg    w_cfg;
    t_result w_next_result;
    t_result w_out_result;
    logic    w_free;
    logic    w_accept;
    logic    w_busy;

    assign i_cmd.ready = w_free;
    assign w_accept    = i_cmd.valid && w_free;

    klcs_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    klcs_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_action     (i_cmd.action),
        .i_led_mask   (i_cmd.led_mask),
        .i_reply_byte (i_cmd.reply_byte),
        .i_cfg        (w_cfg),
        .o_result     (w_next_result),
        .o_busy       (w_busy)
    );

    klcs_out_reg u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_accept),
        .i_result    (w_next_result),
        .i_out_ready (o_res.ready),
        .o_out_valid (o_res.valid),
        .o_result    (w_out_result),
        .o_free      (w_free)
    );

    // Drive the output word
    assign o_res.write_valid = w_out_result.write_valid;
    assign o_res.write_byte  = w_out_result.write_byte;
    assign o_res.done_res    = w_out_result.done_res;
    assign o_res.status      = w_out_result.status;

    // A result never both writes a byte and finishes
    a_write_xor_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !(o_res.write_valid && o_res.done_res))
        else $error("result both writes and finishes");

    // Status is only nonzero on completion
    a_status_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.done_res) |-> (o_res.status == ST_OK))
        else $error("status set without completion");

    // A start taken while idle sends the set-LEDs command next
    a_start_sends_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_busy && (i_cmd.action == ACT_START))
        |=> (o_res.valid && o_res.write_valid && (o_res.write_byte == CMD_SET_LEDS)))
        else $error("start from idle did not send command");

    // Completion always returns the controller to idle
    a_done_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_next_result.done_res) |=> !w_busy)
        else $error("controller busy after completion");

endmodule
